[hw/rtl/v3mu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3mu_pkg
// Operation codes and status codes of the 3D vector math unit.
// ----------------------------------------------------------------------------
package v3mu_pkg;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_ADDS,
		OP_SUB,
		OP_SUBS,
		OP_DIVS,
		OP_MULS,
		OP_EQUAL,
		OP_MAG,
		OP_NORM,
		OP_DOT,
		OP_CROSS,
		OP_PROJ
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_DIVZ,
		ST_SAT
	} status_t;

endpackage

[hw/rtl/vector3_math_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_math_unit
// Pipelined 3D vector ALU on signed fixed-point operands: add, subtract,
// scalar ops, equality, magnitude, normalize, dot, cross and projection.
// ----------------------------------------------------------------------------
// A command is taken on every cycle that start is high; busy stays low. Each
// command returns one result, marked by done for one cycle, in command order,
// one per cycle at full rate. Each command passes through the square-root
// pipeline (one root bit per stage, DATA_WIDTH stages) followed by the
// divider pipeline (one quotient bit per stage, DATA_WIDTH + FRAC_BITS
// stages); every operation travels the same path. done cannot be held off,
// so the receiver must take each transfer in the cycle it appears.
module vector3_math_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [3:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] a_x,
	input  logic signed [DATA_WIDTH-1:0] a_y,
	input  logic signed [DATA_WIDTH-1:0] a_z,
	input  logic signed [DATA_WIDTH-1:0] b_x,
	input  logic signed [DATA_WIDTH-1:0] b_y,
	input  logic signed [DATA_WIDTH-1:0] b_z,
	input  logic signed [DATA_WIDTH-1:0] scalar_in,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_x,
	output logic signed [DATA_WIDTH-1:0] res_y,
	output logic signed [DATA_WIDTH-1:0] res_z,
	output logic signed [DATA_WIDTH-1:0] res_scalar,
	output logic                         is_equal,
	output logic [1:0]                   status
);
	import v3mu_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int W2 = 2 * W;
	localparam int SW = 2 * W + 2;
	localparam int NW = W + F;

	localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

	typedef logic signed [W-1:0] word_t;

	typedef struct packed {
		op_t                func;
		word_t [2:0]        a;
		word_t [2:0]        b;
		word_t              s;
		word_t [2:0]        r;
		word_t              sc;
		logic               eq;
		logic               sat;
		logic               divz;
		word_t              dv;
		logic [W2-1:0]      m;
	} item_t;

	function automatic logic signed [SW-1:0] sxw(input logic [W-1:0] x);
		return {{(SW-W){x[W-1]}}, x};
	endfunction

	function automatic logic signed [SW-1:0] sxp(input logic [W2-1:0] p);
		return {{(SW-W2){p[W2-1]}}, p};
	endfunction

	function automatic word_t sat_w(input logic signed [SW-1:0] v);
		if (v > SMAX) begin
			return SMAX[W-1:0];
		end else if (v < SMIN) begin
			return SMIN[W-1:0];
		end
		return v[W-1:0];
	endfunction

	function automatic logic ovf(input logic signed [SW-1:0] v);
		return (v > SMAX) || (v < SMIN);
	endfunction

	function automatic logic [W-1:0] absw(input logic [W-1:0] x);
		return x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
	endfunction

	assign busy = 1'b0;

	// ---------------- stage 1: capture ----------------
	item_t n1;
	item_t it_s1;
	logic  v_s1;

	always_comb begin
		n1      = '0;
		n1.func = op_t'(func);
		n1.a    = {a_z, a_y, a_x};
		n1.b    = {b_z, b_y, b_x};
		n1.s    = scalar_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= n1;
	end

	// ---------------- stage 2: products ----------------
	item_t              it_s2;
	logic               v_s2;
	logic [W2-1:0]      pab_s2 [3];
	logic [W2-1:0]      paa_s2 [3];
	logic [W2-1:0]      pbb_s2 [3];
	logic [W2-1:0]      pas_s2 [3];
	logic [W2-1:0]      pc1_s2 [3];
	logic [W2-1:0]      pc2_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s2 <= it_s1;
		for (int i = 0; i < 3; i++) begin
			pab_s2[i] <= $signed(it_s1.a[i]) * $signed(it_s1.b[i]);
			paa_s2[i] <= $signed(it_s1.a[i]) * $signed(it_s1.a[i]);
			pbb_s2[i] <= $signed(it_s1.b[i]) * $signed(it_s1.b[i]);
			pas_s2[i] <= $signed(it_s1.a[i]) * $signed(it_s1.s);
		end
		// cross terms: r_i = a_j*b_k - a_k*b_j
		pc1_s2[0] <= $signed(it_s1.a[1]) * $signed(it_s1.b[2]);
		pc2_s2[0] <= $signed(it_s1.a[2]) * $signed(it_s1.b[1]);
		pc1_s2[1] <= $signed(it_s1.a[2]) * $signed(it_s1.b[0]);
		pc2_s2[1] <= $signed(it_s1.a[0]) * $signed(it_s1.b[2]);
		pc1_s2[2] <= $signed(it_s1.a[0]) * $signed(it_s1.b[1]);
		pc2_s2[2] <= $signed(it_s1.a[1]) * $signed(it_s1.b[0]);
	end

	// ---------------- stage 3: sums, simple results ----------------
	item_t                 n3;
	logic signed [SW-1:0]  dsum;
	logic [W2-1:0]         ssa;
	logic [W2-1:0]         ssb;

	always_comb begin
		n3      = it_s2;
		n3.r    = '0;
		n3.sc   = '0;
		n3.eq   = 1'b0;
		n3.sat  = 1'b0;
		n3.divz = 1'b0;
		n3.dv   = '0;
		n3.m    = '0;
		dsum = (sxp(pab_s2[0]) >>> F) + (sxp(pab_s2[1]) >>> F) + (sxp(pab_s2[2]) >>> F);
		ssa  = paa_s2[0] + paa_s2[1] + paa_s2[2];
		ssb  = pbb_s2[0] + pbb_s2[1] + pbb_s2[2];
		case (it_s2.func)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) begin
					n3.r[i] = sat_w(sxw(it_s2.a[i]) + sxw(it_s2.b[i]));
					n3.sat  = n3.sat | ovf(sxw(it_s2.a[i]) + sxw(it_s2.b[i]));
				end
			end
			OP_ADDS: begin
				for (int i = 0; i < 3; i++) begin
					n3.r[i] = sat_w(sxw(it_s2.a[i]) + sxw(it_s2.s));
					n3.sat  = n3.sat | ovf(sxw(it_s2.a[i]) + sxw(it_s2.s));
				end
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					n3.r[i] = sat_w(sxw(it_s2.a[i]) - sxw(it_s2.b[i]));
					n3.sat  = n3.sat | ovf(sxw(it_s2.a[i]) - sxw(it_s2.b[i]));
				end
			end
			OP_SUBS: begin
				for (int i = 0; i < 3; i++) begin
					n3.r[i] = sat_w(sxw(it_s2.a[i]) - sxw(it_s2.s));
					n3.sat  = n3.sat | ovf(sxw(it_s2.a[i]) - sxw(it_s2.s));
				end
			end
			OP_MULS: begin
				for (int i = 0; i < 3; i++) begin
					n3.r[i] = sat_w(sxp(pas_s2[i]) >>> F);
					n3.sat  = n3.sat | ovf(sxp(pas_s2[i]) >>> F);
				end
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					n3.r[i] = sat_w((sxp(pc1_s2[i]) - sxp(pc2_s2[i])) >>> F);
					n3.sat  = n3.sat | ovf((sxp(pc1_s2[i]) - sxp(pc2_s2[i])) >>> F);
				end
			end
			OP_EQUAL: begin
				n3.eq = (it_s2.a == it_s2.b);
			end
			OP_DOT: begin
				n3.sc  = sat_w(dsum);
				n3.sat = ovf(dsum);
			end
			OP_PROJ: begin
				n3.dv  = sat_w(dsum);
				n3.sat = ovf(dsum);
				n3.m   = ssb >> F;
			end
			default: begin
			end
		endcase
	end

	// ---------------- square root: one root bit per stage ----------------
	// entry 0 is the stage-3 register
	item_t          rt_it_s   [0:W];
	logic           rt_v_s    [0:W];
	logic [W2-1:0]  rt_rem_s  [0:W];
	logic [W2-1:0]  rt_root_s [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else begin
			rt_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rt_it_s[0]   <= n3;
		rt_rem_s[0]  <= ssa;
		rt_root_s[0] <= '0;
	end

	for (genvar k = 0; k < W; k++) begin : g_rt
		localparam int SH = 2 * (W - 1 - k);
		logic [W2:0] bitv;
		logic [W2:0] trial;
		logic        ge;

		assign bitv  = (W2 + 1)'(1) << SH;
		assign trial = {1'b0, rt_root_s[k]} + bitv;
		assign ge    = {1'b0, rt_rem_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_it_s[k+1] <= rt_it_s[k];
			if (ge) begin
				rt_rem_s[k+1]  <= rt_rem_s[k] - trial[W2-1:0];
				rt_root_s[k+1] <= (rt_root_s[k] >> 1) + bitv[W2-1:0];
			end else begin
				rt_rem_s[k+1]  <= rt_rem_s[k];
				rt_root_s[k+1] <= rt_root_s[k] >> 1;
			end
		end
	end

	// ---------------- stage 4: divider setup ----------------
	logic [W-1:0]   root;
	item_t          n4;
	logic [W2-1:0]  den4;
	logic [NW-1:0]  num4 [3];
	logic [2:0]     neg4;

	assign root = rt_root_s[W][W-1:0];

	always_comb begin
		n4   = rt_it_s[W];
		den4 = '0;
		neg4 = '0;
		for (int l = 0; l < 3; l++) begin
			num4[l] = '0;
		end
		case (n4.func)
			OP_MAG: begin
				n4.sc  = root[W-1] ? SMAX[W-1:0] : root;
				n4.sat = root[W-1];
			end
			OP_DIVS: begin
				den4    = W2'(absw(n4.s));
				n4.divz = (n4.s == '0);
				for (int l = 0; l < 3; l++) begin
					num4[l] = {absw(n4.a[l]), {F{1'b0}}};
					neg4[l] = n4.a[l][W-1] ^ n4.s[W-1];
				end
			end
			OP_NORM: begin
				den4    = W2'(root);
				n4.divz = (root == '0);
				for (int l = 0; l < 3; l++) begin
					num4[l] = {absw(n4.a[l]), {F{1'b0}}};
					neg4[l] = n4.a[l][W-1];
				end
			end
			OP_PROJ: begin
				den4    = n4.m;
				n4.divz = (n4.m == '0);
				num4[0] = {absw(n4.dv), {F{1'b0}}};
				neg4[0] = n4.dv[W-1];
			end
			default: begin
			end
		endcase
	end

	// ---------------- restoring divider: one quotient bit per stage ----------------
	// numerator bits shift out of nq at the top while quotient bits enter below
	item_t          dv_it_s  [0:NW];
	logic           dv_v_s   [0:NW];
	logic [W2-1:0]  dv_den_s [0:NW];
	logic [2:0]     dv_neg_s [0:NW];
	logic [W2-1:0]  dv_rem_s [0:NW][3];
	logic [NW-1:0]  dv_nq_s  [0:NW][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= rt_v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		dv_it_s[0]  <= n4;
		dv_den_s[0] <= den4;
		dv_neg_s[0] <= neg4;
		for (int l = 0; l < 3; l++) begin
			dv_rem_s[0][l] <= '0;
			dv_nq_s[0][l]  <= num4[l];
		end
	end

	for (genvar j = 0; j < NW; j++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_it_s[j+1]  <= dv_it_s[j];
			dv_den_s[j+1] <= dv_den_s[j];
			dv_neg_s[j+1] <= dv_neg_s[j];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [W2:0] r2;
			logic [W2:0] diff;
			logic        ge;

			assign r2   = {dv_rem_s[j][l], dv_nq_s[j][l][NW-1]};
			assign diff = r2 - {1'b0, dv_den_s[j]};
			assign ge   = r2 >= {1'b0, dv_den_s[j]};

			always_ff @(posedge clk) begin
				dv_rem_s[j+1][l] <= ge ? diff[W2-1:0] : r2[W2-1:0];
				dv_nq_s[j+1][l]  <= {dv_nq_s[j][l][NW-2:0], ge};
			end
		end
	end

	// ---------------- stage 5: signed quotients ----------------
	item_t                 n5;
	word_t                 t5;
	logic signed [SW-1:0]  qs [3];
	item_t                 it_s5;
	word_t                 t_s5;
	logic                  v_s5;

	always_comb begin
		n5 = dv_it_s[NW];
		t5 = '0;
		for (int l = 0; l < 3; l++) begin
			qs[l] = dv_neg_s[NW][l] ? -{{(SW-NW){1'b0}}, dv_nq_s[NW][l]}
			                        : {{(SW-NW){1'b0}}, dv_nq_s[NW][l]};
		end
		case (n5.func) inside
			OP_DIVS, OP_NORM: begin
				for (int l = 0; l < 3; l++) begin
					n5.r[l] = sat_w(qs[l]);
					n5.sat  = n5.sat | ovf(qs[l]);
				end
			end
			OP_PROJ: begin
				t5     = sat_w(qs[0]);
				n5.sat = n5.sat | ovf(qs[0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= dv_v_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		it_s5 <= n5;
		t_s5  <= t5;
	end

	// ---------------- stage 6: projection scaling ----------------
	item_t          it_s6;
	logic           v_s6;
	logic [W2-1:0]  pt_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		it_s6 <= it_s5;
		for (int l = 0; l < 3; l++) begin
			pt_s6[l] <= $signed(it_s5.b[l]) * $signed(t_s5);
		end
	end

	// ---------------- stage 7: output register ----------------
	item_t    n7;
	status_t  st7;
	item_t    it_s7;
	status_t  st_s7;
	logic     v_s7;

	always_comb begin
		n7 = it_s6;
		if (n7.func == OP_PROJ) begin
			for (int l = 0; l < 3; l++) begin
				n7.r[l] = sat_w(sxp(pt_s6[l]) >>> F);
				n7.sat  = n7.sat | ovf(sxp(pt_s6[l]) >>> F);
			end
		end
		if (n7.divz) begin
			n7.r  = '0;
			n7.sc = '0;
			st7   = ST_DIVZ;
		end else if (n7.sat) begin
			st7 = ST_SAT;
		end else begin
			st7 = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		it_s7 <= n7;
		st_s7 <= st7;
	end

	assign done       = v_s7;
	assign res_x      = it_s7.r[0];
	assign res_y      = it_s7.r[1];
	assign res_z      = it_s7.r[2];
	assign res_scalar = it_s7.sc;
	assign is_equal   = it_s7.eq;
	assign status     = st_s7;

endmodule

[hw/rtl/v3mu_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3mu_chk
// Port-level checks of the vector math unit: fixed latency and result codes.
// ----------------------------------------------------------------------------
module v3mu_chk #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [3:0]                   func,
	input logic signed [DATA_WIDTH-1:0] a_x,
	input logic signed [DATA_WIDTH-1:0] a_y,
	input logic signed [DATA_WIDTH-1:0] a_z,
	input logic signed [DATA_WIDTH-1:0] b_x,
	input logic signed [DATA_WIDTH-1:0] b_y,
	input logic signed [DATA_WIDTH-1:0] b_z,
	input logic signed [DATA_WIDTH-1:0] scalar_in,
	input logic                         done,
	input logic signed [DATA_WIDTH-1:0] res_x,
	input logic signed [DATA_WIDTH-1:0] res_y,
	input logic signed [DATA_WIDTH-1:0] res_z,
	input logic signed [DATA_WIDTH-1:0] res_scalar,
	input logic                         is_equal,
	input logic [1:0]                   status
);
	import v3mu_pkg::*;

	localparam int LAT = 2 * DATA_WIDTH + FRAC_BITS + 7;

	// every accepted command comes back after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after command transfer");

	// no result without a command
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a command transfer");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DIVZ) |-> (res_x == '0 && res_y == '0 && res_z == '0
			&& res_scalar == '0 && !is_equal))
		else $error("divide-by-zero result not cleared");

	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_equal) |-> (status == ST_OK && res_x == '0 && res_y == '0
			&& res_z == '0 && res_scalar == '0))
		else $error("equality result carries other fields");

endmodule

bind vector3_math_unit v3mu_chk #(
	.DATA_WIDTH(DATA_WIDTH),
	.FRAC_BITS (FRAC_BITS)
) u_v3mu_chk (.*);
